### sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear-probing hash table core: request
// and result codes, slot status codes and the packed slot word.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 11;   // size register width
  localparam int CNT_W  = 11;   // item_count port width

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  // result status codes
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_MISS  = 2'd2;
  localparam logic [1:0] RES_EMPTY = 2'd3;

  // slot status codes
  localparam logic [1:0] SLOT_AVAIL = 2'd0;
  localparam logic [1:0] SLOT_OCC   = 2'd1;
  localparam logic [1:0] SLOT_DEL   = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_CFG_RST = 11'd1024;

  // one table entry as stored in memory
  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

### sv/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/linear_probing_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probing_hash_table_core
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// One request at a time. After start is taken, busy stays high until the
// cycle of the result beat, in which a new start may already be taken. The
// home slot (key mod table size) comes from a shift-subtract remainder unit,
// one key bit per cycle. The probe then reads one slot per cycle through
// the single read port of the slot memory until a slot or the probe budget
// settles the request, and out_valid is registered from that probe step; an
// unused opcode, an insert into a full table and a remove or lookup on an
// empty table skip the remainder and the probe and answer from S_FIN.
// After reset the core sweeps the slot memory to mark every slot free, one
// slot per cycle, with busy high; configuration writes are taken during
// that sweep. The result beat lasts exactly one cycle and cannot be held
// off, so the receiver must take it when out_valid is high.
// ----------------------------------------------------------------------------
module linear_probing_hash_table_core
  import lpht_pkg::*;
#(
  parameter int SLOT_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  // request
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_req_type,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  // result
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [CNT_W-1:0]        out_item_count
);

  localparam int IW = $clog2(SLOT_DEPTH);  // slot index width
  localparam int SW = IW + 1;              // size / count width
  localparam int LW = SW + 1;              // probe budget width
  localparam int DW = $clog2(KEY_W);       // remainder step counter width
  localparam int WORD_W = $bits(slot_t);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] size_cfg_r;
  logic [SW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    clr_r, clr_nxt;

  logic [1:0]       req_r, req_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [KEY_W-1:0] div_sh_r, div_sh_nxt;
  logic [SW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    div_cnt_r, div_cnt_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [LW-1:0]    left_r, left_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_rv_r, out_rv_nxt;

  logic [SW-1:0]    size_eff;
  logic [SW:0]      rem_shift;
  logic [SW-1:0]    idx_inc;
  logic [LW-1:0]    left_dec;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  slot_t            ram_wslot;
  logic [WORD_W-1:0] ram_rdata;
  slot_t            rd_slot;

  // effective size: zero acts as one, clamp to the memory depth
  always_comb begin
    if (size_cfg_r == '0) begin
      size_eff = SW'(1);
    end else if (32'(size_cfg_r) > 32'(SLOT_DEPTH)) begin
      size_eff = SW'(SLOT_DEPTH);
    end else begin
      size_eff = SW'(size_cfg_r);
    end
  end

  assign rd_slot   = slot_t'(ram_rdata);
  assign rem_shift = {rem_r, div_sh_r[KEY_W-1]};
  assign idx_inc   = SW'(idx_r) + SW'(1);
  assign left_dec  = left_r - LW'(1);

  // main control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    div_sh_nxt     = div_sh_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rv_nxt     = out_rv_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wslot      = '{status: SLOT_OCC, key: key_r, value: val_r};

    unique case (state_r)
      // sweep every slot to free after reset
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wslot = '{status: SLOT_AVAIL, key: '0, value: '0};
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == IW'(SLOT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request; settle the trivial answers at once
      S_IDLE: begin
        if (start) begin
          req_nxt        = in_req_type;
          key_nxt        = in_key;
          val_nxt        = in_value;
          div_sh_nxt     = in_key;
          rem_nxt        = '0;
          div_cnt_nxt    = '0;
          out_status_nxt = RES_OK;
          out_rv_nxt     = '1;
          state_nxt      = S_DIV;
          unique case (in_req_type)
            REQ_INSERT: begin
              if (count_r >= size_eff) begin
                out_status_nxt = RES_FULL;
                state_nxt      = S_FIN;
              end
            end
            REQ_REMOVE, REQ_LOOKUP: begin
              if (count_r == '0) begin
                out_status_nxt = RES_EMPTY;
                state_nxt      = S_FIN;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // home slot: one remainder bit per cycle
      S_DIV: begin
        if (rem_shift >= (SW+1)'(size_eff)) begin
          rem_nxt = SW'(rem_shift - (SW+1)'(size_eff));
        end else begin
          rem_nxt = SW'(rem_shift);
        end
        div_sh_nxt  = div_sh_r << 1;
        div_cnt_nxt = div_cnt_r + DW'(1);
        if (div_cnt_r == DW'(KEY_W - 1)) begin
          idx_nxt   = rem_nxt[IW-1:0];
          left_nxt  = (req_r == REQ_INSERT) ? LW'(size_eff) : LW'(size_eff) + LW'(1);
          state_nxt = S_PROBE;
        end
      end

      // one slot per cycle; read data belongs to idx_r
      S_PROBE: begin
        if (req_r == REQ_INSERT) begin
          if (rd_slot.status != SLOT_OCC) begin
            ram_we    = 1'b1;
            count_nxt = count_r + SW'(1);
            state_nxt = S_IDLE;
            out_valid_nxt = 1'b1;
          end else if (left_dec == '0) begin
            out_status_nxt = RES_FULL;
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
          end
        end else begin
          if (rd_slot.status == SLOT_AVAIL) begin
            out_status_nxt = RES_MISS;
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
          end else if (rd_slot.status == SLOT_OCC && rd_slot.key == key_r) begin
            if (req_r == REQ_REMOVE) begin
              ram_we    = 1'b1;
              ram_wslot = '{status: SLOT_DEL, key: rd_slot.key, value: rd_slot.value};
              count_nxt = count_r - SW'(1);
            end else begin
              out_rv_nxt = rd_slot.value;
            end
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end else if (left_dec == '0) begin
            out_status_nxt = RES_MISS;
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
          end
        end
        // keep walking: next slot with wrap at the table size
        if (state_nxt == S_PROBE) begin
          left_nxt = left_dec;
          idx_nxt  = (idx_inc == size_eff) ? '0 : idx_inc[IW-1:0];
        end
      end

      // answer decided on accept
      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      size_cfg_r  <= SIZE_CFG_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        size_cfg_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    div_sh_r     <= div_sh_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    idx_r        <= idx_nxt;
    left_r       <= left_nxt;
    out_status_r <= out_status_nxt;
    out_rv_r     <= out_rv_nxt;
  end

  // slot memory: read address follows the next probe index
  lpht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wslot),
    .rd_addr (idx_nxt),
    .rd_data (ram_rdata)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rv_r;
  assign out_item_count = CNT_W'(count_r);

endmodule

### sv/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table core, bound to every core instance.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [1:0]              out_status,
  input logic signed [VAL_W-1:0] out_read_value,
  input logic [CNT_W-1:0]        out_item_count
);

  // an accepted request keeps the core busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // the result beat comes with the core ready again
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // any answer other than ok carries -1
  a_rv_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != RES_OK) |-> (out_read_value == -1))
    else $error("read_value not -1 on failed request");

  // an empty answer reports zero items
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == RES_EMPTY) |-> (out_item_count == '0))
    else $error("empty status with nonzero item count");

  // the item count moves only with a result beat
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !out_valid) |-> $stable(out_item_count))
    else $error("item count changed without result beat");

endmodule

bind linear_probing_hash_table_core lpht_checker u_lpht_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probing_hash_table_core. A scoreboard keeps
// its own copy of the slot table and predicts status, read value and item
// count for every accepted request. Stimulus starts with a directed pass
// over empty and full tables, tombstones and out-of-range sizes. A random
// pass follows, with insert/lookup/remove traffic on a pool of live keys
// and clustered home slots, at several table sizes.
// ----------------------------------------------------------------------------
module tb
  import lpht_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_DEPTH  = 1024;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_ITEMS = 58;

  typedef struct {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] item_count;
  } result_t;

  // Shadow copy of the slot table; predicts one result per request beat.
  class table_scoreboard;
    logic [1:0]       slot_state [SLOT_DEPTH];
    logic [KEY_W-1:0] slot_key   [SLOT_DEPTH];
    logic [VAL_W-1:0] slot_val   [SLOT_DEPTH];
    int unsigned      occupied;
    logic [CFG_W-1:0] size_reg;
    result_t          pending_results[$];
    int               errors;
    int               op_seen[4];
    int               status_seen[4];

    function new();
      foreach (slot_state[i]) slot_state[i] = SLOT_AVAIL;
      occupied = 0;
      size_reg = SIZE_CFG_RST;
      errors   = 0;
      foreach (op_seen[i]) begin
        op_seen[i]     = 0;
        status_seen[i] = 0;
      end
    endfunction

    function void set_size_cfg(logic [CFG_W-1:0] v);
      size_reg = v;
    endfunction

    // size 0 acts as 1, anything above the memory depth is clamped
    function int unsigned span();
      int unsigned s;
      s = size_reg;
      if (s == 0) s = 1;
      if (s > SLOT_DEPTH) s = SLOT_DEPTH;
      return s;
    endfunction

    // first occupied slot holding key, stopping at a free slot or size+1 visits
    function int find_slot(logic [KEY_W-1:0] key, int unsigned sz);
      int unsigned idx;
      int unsigned n;
      idx = key % sz;
      for (n = 0; n <= sz; n++) begin
        if (slot_state[idx] == SLOT_AVAIL) break;
        if (slot_state[idx] == SLOT_OCC && slot_key[idx] == key) return int'(idx);
        idx = (idx + 1) % sz;
      end
      return -1;
    endfunction

    function void note_request(logic [1:0] req, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] val);
      int unsigned sz;
      int unsigned idx;
      int unsigned n;
      int          hit;
      bit          placed;
      result_t     r;
      sz           = span();
      r.status     = RES_OK;
      r.read_value = '1;
      op_seen[req]++;
      unique case (req)
        REQ_INSERT: begin
          if (occupied >= sz) begin
            r.status = RES_FULL;
          end else begin
            idx    = key % sz;
            placed = 1'b0;
            for (n = 0; n < sz && !placed; n++) begin
              if (slot_state[idx] != SLOT_OCC) begin
                slot_state[idx] = SLOT_OCC;
                slot_key[idx]   = key;
                slot_val[idx]   = val;
                occupied++;
                placed = 1'b1;
              end else begin
                idx = (idx + 1) % sz;
              end
            end
            if (!placed) r.status = RES_FULL;
          end
        end
        REQ_REMOVE, REQ_LOOKUP: begin
          if (occupied == 0) begin
            r.status = RES_EMPTY;
          end else begin
            hit = find_slot(key, sz);
            if (hit < 0) begin
              r.status = RES_MISS;
            end else if (req == REQ_REMOVE) begin
              slot_state[hit] = SLOT_DEL;
              occupied--;
            end else begin
              r.read_value = slot_val[hit];
            end
          end
        end
        default: ;  // unused opcode changes nothing
      endcase
      r.item_count = CNT_W'(occupied);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, name, exp, act);
      end
    endfunction

    function void check_result(logic [1:0] st, logic [VAL_W-1:0] rv,
                               logic [CNT_W-1:0] cnt);
      result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: status %0d value 0x%08h count %0d",
                 $time, st, rv, cnt);
        return;
      end
      e = pending_results.pop_front();
      status_seen[e.status]++;
      compare_field("status", 32'(e.status), 32'(st));
      compare_field("read_value", e.read_value, rv);
      compare_field("item_count", 32'(e.item_count), 32'(cnt));
    endfunction

    function void check_drained();
      if (pending_results.size() != 0) begin
        errors += pending_results.size();
        $display("%0t: %0d results never arrived", $time, pending_results.size());
      end
    endfunction
  endclass

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    cfg_wr_en      = 1'b0;
  logic [CFG_W-1:0]        cfg_wr_data    = '0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic [1:0]              in_req_type    = REQ_NOP;
  logic [KEY_W-1:0]        in_key         = '0;
  logic signed [VAL_W-1:0] in_value       = '0;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic [CNT_W-1:0]        out_item_count;

  table_scoreboard  sb = new();
  logic [KEY_W-1:0] live_keys[$];
  int unsigned      cur_span   = SLOT_DEPTH;
  bit               idle_on    = 1'b1;
  int               sizes_used = 0;
  int               cycles     = 0;

  linear_probing_hash_table_core #(.SLOT_DEPTH(SLOT_DEPTH)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_read_value(out_read_value),
    .out_item_count(out_item_count)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached, %0d results pending", $time,
               sb.pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // monitor: register writes, accepted request beats and result beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_size_cfg(cfg_wr_data);
      if (start && !busy) sb.note_request(in_req_type, in_key, in_value);
      if (out_valid) sb.check_result(out_status, out_read_value, out_item_count);
    end
  end

  // hold start low until every pending result is back and the core is idle;
  // the first edge lets a beat accepted just now reach the scoreboard
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_size_cfg(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_span  = (v == 0) ? 1 : (v > SLOT_DEPTH) ? SLOT_DEPTH : v;
    sizes_used++;
  endtask

  // one request beat; start stays high on return so back-to-back beats need
  // no extra edge, and any gap lowers it first
  task automatic send_request(input logic [1:0] req, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    if (idle_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    in_value    <= val;
    do @(posedge clk); while (busy);
  endtask

  // random key, or one landing a few slots past a multiple of the size
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] base;
    base = $urandom;
    if ($urandom_range(1) == 0) return base;
    return base - (base % cur_span) + $urandom_range(0, 3);
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    if (live_keys.size() != 0 && $urandom_range(99) < 80)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return fresh_key();
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] size_val);
    int               pick;
    logic [1:0]       req;
    logic [KEY_W-1:0] key;
    write_size_cfg(size_val);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        req = REQ_INSERT;
        key = ($urandom_range(99) < 10) ? pool_key() : fresh_key();
        live_keys.push_back(key);
        if (live_keys.size() > 48) void'(live_keys.pop_front());
      end else if (pick < 62) begin
        req = REQ_REMOVE;
        key = pool_key();
      end else if (pick < 92) begin
        req = REQ_LOOKUP;
        key = pool_key();
      end else if (pick < 95) begin
        req = REQ_NOP;
        key = $urandom;
      end else begin
        // noise: any opcode, any key
        req = 2'($urandom_range(3));
        key = $urandom;
      end
      send_request(req, key, $urandom);
      if ($urandom_range(99) < 2) wait_drained();
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_sizes[11];
    phase_sizes = '{11'd16, 11'd64, 11'd7, 11'd128, 11'd1024, 11'd2047,
                    11'd1023, 11'd3, 11'd1, 11'd0, 11'd1024};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: four-slot table, empty, full, tombstones
    write_size_cfg(11'd4);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_NOP,    32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'h0000_0000, 32'h8000_0000);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'd4,         32'h0000_0000);
    send_request(REQ_INSERT, 32'd8,         32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'd1,         32'h1234_5678);  // table full
    send_request(REQ_LOOKUP, 32'd4,         32'h0);
    send_request(REQ_LOOKUP, 32'd12,        32'h0);          // probes size+1, miss
    send_request(REQ_REMOVE, 32'd4,         32'h0);          // leaves a tombstone
    send_request(REQ_LOOKUP, 32'd8,         32'h0);          // skips the tombstone
    send_request(REQ_LOOKUP, 32'd4,         32'h0);
    send_request(REQ_INSERT, 32'd16,        32'd123);        // reuses the tombstone
    send_request(REQ_REMOVE, 32'd16,        32'h0);
    send_request(REQ_NOP,    32'h0000_0000, 32'h8000_0000);
    // size zero acts as one slot; count already exceeds it
    write_size_cfg(11'd0);
    send_request(REQ_INSERT, 32'd5,         32'd5);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0);
    send_request(REQ_LOOKUP, 32'd5,         32'h0);
    // oversize clamps to the memory depth; some old entries become unreachable
    write_size_cfg(11'd2047);
    send_request(REQ_LOOKUP, 32'd8,         32'h0);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_REMOVE, 32'h0000_0000, 32'h0);

    // random traffic; the first full-size phase runs without random idle gaps
    foreach (phase_sizes[p]) begin
      idle_on = (p != 4);
      run_phase(phase_sizes[p]);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    sb.check_drained();
    $display("Covered %0d inserts, %0d removes, %0d lookups, %0d unused ops at %0d size settings",
             sb.op_seen[REQ_INSERT], sb.op_seen[REQ_REMOVE], sb.op_seen[REQ_LOOKUP],
             sb.op_seen[REQ_NOP], sizes_used);
    $display("Outcomes: %0d ok, %0d full, %0d miss, %0d empty; %0d errors",
             sb.status_seen[RES_OK], sb.status_seen[RES_FULL], sb.status_seen[RES_MISS],
             sb.status_seen[RES_EMPTY], sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
